[rtl/core/c8sst_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// c8sst_pkg: shared types and constants of the 8-bit execute unit
// Opcode codes, decoded instruction record, channel payloads, reset values
// and queue sizing used by the front, the queue and the back of the unit.
// ---------------------------------------------------------------------------
package c8sst_pkg;

   typedef enum logic [4:0] {
      OPC_ROL_A = 5'd0,
      OPC_ROL_M = 5'd1,
      OPC_ROR_A = 5'd2,
      OPC_ROR_M = 5'd3,
      OPC_RTI   = 5'd4,
      OPC_RTS   = 5'd5,
      OPC_SBC   = 5'd6,
      OPC_SEC   = 5'd7,
      OPC_SED   = 5'd8,
      OPC_SEI   = 5'd9,
      OPC_STA   = 5'd10,
      OPC_STX   = 5'd11,
      OPC_STY   = 5'd12,
      OPC_TAX   = 5'd13,
      OPC_TAY   = 5'd14,
      OPC_TSX   = 5'd15,
      OPC_TXA   = 5'd16,
      OPC_TXS   = 5'd17,
      OPC_TYA   = 5'd18
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_ROTATE,
      KIND_RTI,
      KIND_RTS,
      KIND_SBC,
      KIND_SETF,
      KIND_STORE,
      KIND_XFER
   } kind_type;

   typedef enum logic [1:0] {
      SEL_A,
      SEL_X,
      SEL_Y,
      SEL_S
   } reg_sel_type;

   localparam int FLAG_C_BIT = 0;
   localparam int FLAG_Z_BIT = 1;
   localparam int FLAG_V_BIT = 6;
   localparam int FLAG_N_BIT = 7;

   localparam logic [7:0] FLAG_C_MASK = 8'h01;
   localparam logic [7:0] FLAG_I_MASK = 8'h04;
   localparam logic [7:0] FLAG_D_MASK = 8'h08;
   localparam logic [7:0] SIGN_MASK   = 8'h80;
   localparam logic [7:0] STATUS_MASK = 8'hCF;

   localparam logic [7:0]  RESET_SP    = 8'hFD;
   localparam logic [7:0]  RESET_FLAGS = FLAG_I_MASK;
   localparam logic [7:0]  RTI_SP_STEP = 8'd3;
   localparam logic [7:0]  RTS_SP_STEP = 8'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QUEUE_PTR_W-1:0] QUEUE_PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] QUEUE_CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   typedef struct packed {
      logic [4:0] opcode;
      logic [7:0] operand;
      logic [7:0] pull_status;
      logic [7:0] pull_low;
      logic [7:0] pull_high;
   } req_payload_type;

   typedef struct packed {
      logic        write_enable;
      logic [7:0]  write_data;
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
      logic [7:0]  status_out;
      logic [15:0] pc_out;
   } rsp_payload_type;

   typedef struct packed {
      kind_type    kind;
      logic        rot_right;
      logic        rot_mem;
      reg_sel_type src;
      reg_sel_type dst;
      logic        set_nz;
      logic [7:0]  set_mask;
      logic        step_pc;
      logic [7:0]  operand;
      logic [7:0]  pull_status;
      logic [7:0]  pull_low;
      logic [7:0]  pull_high;
   } decoded_type;

endpackage
`default_nettype wire

[rtl/core/c8sst_channels.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// c8sst channels: valid/ready interfaces of the 8-bit execute unit
// One interface for the instruction channel and one for the result channel.
// ---------------------------------------------------------------------------
interface c8sst_req_if;
   logic                        valid;
   logic                        ready;
   c8sst_pkg::req_payload_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface c8sst_rsp_if;
   logic                        valid;
   logic                        ready;
   c8sst_pkg::rsp_payload_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/c8sst_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// c8sst_front: instruction intake and decode
// Accepts instructions, decodes the opcode into an execution record and
// holds it in a pipeline register until the queue takes it.
// ---------------------------------------------------------------------------
module c8sst_front (
   input  logic                    clock,
   input  logic                    reset,
   c8sst_req_if.sink               req_chan,
   output logic                    dec_valid,
   input  logic                    dec_ready,
   output c8sst_pkg::decoded_type  dec_data
);
   import c8sst_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   decoded_type data_ff;
   decoded_type data_in;
   logic        take;

   assign req_chan.ready = !valid_ff || dec_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !dec_ready);

   always_comb begin
      data_in             = '0;
      data_in.kind        = KIND_NOP;
      data_in.src         = SEL_A;
      data_in.dst         = SEL_A;
      data_in.operand     = req_chan.data.operand;
      data_in.pull_status = req_chan.data.pull_status;
      data_in.pull_low    = req_chan.data.pull_low;
      data_in.pull_high   = req_chan.data.pull_high;
      unique case (req_chan.data.opcode)
         OPC_ROL_A: begin
            data_in.kind    = KIND_ROTATE;
            data_in.step_pc = 1'b1;
         end
         OPC_ROL_M: begin
            data_in.kind    = KIND_ROTATE;
            data_in.rot_mem = 1'b1;
         end
         OPC_ROR_A: begin
            data_in.kind      = KIND_ROTATE;
            data_in.rot_right = 1'b1;
            data_in.step_pc   = 1'b1;
         end
         OPC_ROR_M: begin
            data_in.kind      = KIND_ROTATE;
            data_in.rot_right = 1'b1;
            data_in.rot_mem   = 1'b1;
         end
         OPC_RTI: data_in.kind = KIND_RTI;
         OPC_RTS: data_in.kind = KIND_RTS;
         OPC_SBC: data_in.kind = KIND_SBC;
         OPC_SEC: begin
            data_in.kind     = KIND_SETF;
            data_in.set_mask = FLAG_C_MASK;
            data_in.step_pc  = 1'b1;
         end
         OPC_SED: begin
            data_in.kind     = KIND_SETF;
            data_in.set_mask = FLAG_D_MASK;
            data_in.step_pc  = 1'b1;
         end
         OPC_SEI: begin
            data_in.kind     = KIND_SETF;
            data_in.set_mask = FLAG_I_MASK;
            data_in.step_pc  = 1'b1;
         end
         OPC_STA: begin
            data_in.kind = KIND_STORE;
            data_in.src  = SEL_A;
         end
         OPC_STX: begin
            data_in.kind = KIND_STORE;
            data_in.src  = SEL_X;
         end
         OPC_STY: begin
            data_in.kind = KIND_STORE;
            data_in.src  = SEL_Y;
         end
         OPC_TAX: begin
            data_in.kind    = KIND_XFER;
            data_in.src     = SEL_A;
            data_in.dst     = SEL_X;
            data_in.set_nz  = 1'b1;
            data_in.step_pc = 1'b1;
         end
         OPC_TAY: begin
            data_in.kind    = KIND_XFER;
            data_in.src     = SEL_A;
            data_in.dst     = SEL_Y;
            data_in.set_nz  = 1'b1;
            data_in.step_pc = 1'b1;
         end
         OPC_TSX: begin
            data_in.kind    = KIND_XFER;
            data_in.src     = SEL_S;
            data_in.dst     = SEL_X;
            data_in.set_nz  = 1'b1;
            data_in.step_pc = 1'b1;
         end
         OPC_TXA: begin
            data_in.kind    = KIND_XFER;
            data_in.src     = SEL_X;
            data_in.dst     = SEL_A;
            data_in.set_nz  = 1'b1;
            data_in.step_pc = 1'b1;
         end
         OPC_TXS: begin
            data_in.kind    = KIND_XFER;
            data_in.src     = SEL_X;
            data_in.dst     = SEL_S;
            data_in.step_pc = 1'b1;
         end
         OPC_TYA: begin
            data_in.kind    = KIND_XFER;
            data_in.src     = SEL_Y;
            data_in.dst     = SEL_A;
            data_in.set_nz  = 1'b1;
            data_in.step_pc = 1'b1;
         end
         default: data_in.kind = KIND_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign dec_valid = valid_ff;
   assign dec_data  = data_ff;

endmodule
`default_nettype wire

[rtl/core/c8sst_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// c8sst_queue: decoded instruction queue
// A short first-in first-out buffer that lets the front and the back of the
// unit stall independently.
// ---------------------------------------------------------------------------
module c8sst_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  c8sst_pkg::decoded_type  push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output c8sst_pkg::decoded_type  pop_data
);
   import c8sst_pkg::*;

   decoded_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QUEUE_CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_LAST) ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_LAST) ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/c8sst_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// c8sst_back: instruction execution and register file
// Executes one decoded instruction per cycle while results are taken, against
// A, X, Y, S, P and PC and places the result in an output register.
// ---------------------------------------------------------------------------
module c8sst_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    exe_valid,
   output logic                    exe_ready,
   input  c8sst_pkg::decoded_type  exe_data,
   c8sst_rsp_if.source             rsp_chan
);
   import c8sst_pkg::*;

   logic [7:0]      a_ff;
   logic [7:0]      a_in;
   logic [7:0]      x_ff;
   logic [7:0]      x_in;
   logic [7:0]      y_ff;
   logic [7:0]      y_in;
   logic [7:0]      s_ff;
   logic [7:0]      s_in;
   logic [7:0]      p_ff;
   logic [7:0]      p_in;
   logic [15:0]     pc_ff;
   logic [15:0]     pc_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic            fire;
   logic [7:0]      src_val;
   logic [7:0]      rot_src;
   logic [7:0]      rot_res;
   logic            rot_carry;
   logic [8:0]      diff;
   logic [7:0]      sbc_res;
   logic            we;
   logic [7:0]      wd;
   logic            nz_en;
   logic [7:0]      nz_val;

   assign exe_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign fire         = exe_valid && exe_ready;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      case (exe_data.src)
         SEL_A:   src_val = a_ff;
         SEL_X:   src_val = x_ff;
         SEL_Y:   src_val = y_ff;
         SEL_S:   src_val = s_ff;
         default: src_val = a_ff;
      endcase
   end

   assign rot_src   = exe_data.rot_mem ? exe_data.operand : a_ff;
   assign rot_res   = exe_data.rot_right ? {p_ff[FLAG_C_BIT], rot_src[7:1]}
                                         : {rot_src[6:0], p_ff[FLAG_C_BIT]};
   assign rot_carry = exe_data.rot_right ? rot_src[0] : rot_src[7];

   assign diff    = {1'b0, a_ff} - {1'b0, exe_data.operand} - {8'd0, ~p_ff[FLAG_C_BIT]};
   assign sbc_res = diff[7:0];

   always_comb begin
      a_in   = a_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      s_in   = s_ff;
      p_in   = p_ff;
      pc_in  = pc_ff;
      we     = 1'b0;
      wd     = '0;
      nz_en  = 1'b0;
      nz_val = '0;
      unique case (exe_data.kind)
         KIND_ROTATE: begin
            p_in[FLAG_C_BIT] = rot_carry;
            nz_en            = 1'b1;
            nz_val           = rot_res;
            if (exe_data.rot_mem) begin
               we = 1'b1;
               wd = rot_res;
            end else begin
               a_in = rot_res;
            end
         end
         KIND_RTI: begin
            p_in  = exe_data.pull_status & STATUS_MASK;
            pc_in = {exe_data.pull_high, exe_data.pull_low};
            s_in  = s_ff + RTI_SP_STEP;
         end
         KIND_RTS: begin
            pc_in = {exe_data.pull_high, exe_data.pull_low} + 16'd1;
            s_in  = s_ff + RTS_SP_STEP;
         end
         KIND_SBC: begin
            a_in             = sbc_res;
            p_in[FLAG_C_BIT] = ~diff[8];
            p_in[FLAG_V_BIT] = |((a_ff ^ exe_data.operand) & (a_ff ^ sbc_res) & SIGN_MASK);
            nz_en            = 1'b1;
            nz_val           = sbc_res;
         end
         KIND_SETF: p_in = p_ff | exe_data.set_mask;
         KIND_STORE: begin
            we = 1'b1;
            wd = src_val;
         end
         KIND_XFER: begin
            case (exe_data.dst)
               SEL_A:   a_in = src_val;
               SEL_X:   x_in = src_val;
               SEL_Y:   y_in = src_val;
               SEL_S:   s_in = src_val;
               default: a_in = src_val;
            endcase
            nz_en  = exe_data.set_nz;
            nz_val = src_val;
         end
         default: ;
      endcase
      if (nz_en) begin
         p_in[FLAG_N_BIT] = nz_val[7];
         p_in[FLAG_Z_BIT] = (nz_val == 8'd0);
      end
      if (exe_data.step_pc) begin
         pc_in = pc_ff + 16'd1;
      end
   end

   always_comb begin
      rsp_data_in.write_enable = we;
      rsp_data_in.write_data   = wd;
      rsp_data_in.acc_out      = a_in;
      rsp_data_in.x_out        = x_in;
      rsp_data_in.y_out        = y_in;
      rsp_data_in.sp_out       = s_in;
      rsp_data_in.status_out   = p_in & STATUS_MASK;
      rsp_data_in.pc_out       = pc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         s_ff         <= RESET_SP;
         p_ff         <= RESET_FLAGS;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            a_ff  <= a_in;
            x_ff  <= x_in;
            y_ff  <= y_in;
            s_ff  <= s_in;
            p_ff  <= p_in & STATUS_MASK;
            pc_ff <= pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/core/cpu8_shift_subtract_transfer_unit_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cpu8_shift_subtract_transfer_unit_core: 8-bit CPU execute unit
// Executes rotate, subtract with borrow, return, flag set, store and
// transfer instructions on a kept A, X, Y, S, P and PC register file.
// ---------------------------------------------------------------------------
// The unit sustains one instruction per clock cycle while results are taken:
// a new instruction can be accepted each such cycle; its result transfer
// appears once the front decode register, the queue and the back result
// register are passed. The back stage sets the rate, as it updates the whole
// register file and flags together for each instruction. A two-entry queue
// between decode and execute lets either side stall without stopping the
// other until the queue fills, so the front keeps taking instructions while
// a result waits to be taken. Every result carries the full register
// file after the instruction, plus the store byte and its write enable.
module cpu8_shift_subtract_transfer_unit_core (
   input  logic         clock,
   input  logic         reset,
   c8sst_req_if.sink    req_chan,
   c8sst_rsp_if.source  rsp_chan
);
   import c8sst_pkg::*;

   logic        dec_valid;
   logic        dec_ready;
   decoded_type dec_data;
   logic        exe_valid;
   logic        exe_ready;
   decoded_type exe_data;

   c8sst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .dec_valid (dec_valid),
      .dec_ready (dec_ready),
      .dec_data  (dec_data)
   );

   c8sst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (dec_valid),
      .push_ready (dec_ready),
      .push_data  (dec_data),
      .pop_valid  (exe_valid),
      .pop_ready  (exe_ready),
      .pop_data   (exe_data)
   );

   c8sst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .exe_valid (exe_valid),
      .exe_ready (exe_ready),
      .exe_data  (exe_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
